// File: hw/rtl/gbsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbsd_pkg;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam int unsigned CELL_W = 9;
  localparam int unsigned SIG_W  = 8;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned LEVEL_W = 13;
endpackage
`default_nettype wire

// File: hw/rtl/gbsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gbsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, read registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/grid_bfs_signal_decay.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: written when idle and in range, no result; busy stays low.
// Query: source scan in row order, then a sweep that clears the visit memory
//   (every cell of the full grid, 4096 at 64x64), then BFS that dequeues each cell,
//   probes its four neighbours and skips edges off the grid; the pace is set by the
//   one read port of each memory.
// Result: one cycle on out_valid; the receiver cannot stall. Reset: synchronous active low.
module grid_bfs_signal_decay #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_kind,
  input  wire logic [5:0] in_row,
  input  wire logic [5:0] in_col,
  input  wire logic signed [8:0] in_cell_value,
  output logic            out_valid,
  output logic [7:0]      out_signal,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [gbsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);
  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned QW = $clog2(CELLS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_CLR, S_DEQ_RD, S_DEQ_WAIT, S_NB_SEL,
    S_NB_WAIT, S_NB_CHK, S_DONE
  } state_t;

  state_t state_r;
  logic [6:0] rows_r, cols_r;
  logic [10:0] m_w, n_w;
  logic [RW-1:0] trow_r, pr_r, sr_r;
  logic [CW-1:0] tcol_r, pc_r, sc_r;
  logic [RW:0] sr_cnt_r, nr_r;
  logic [CW:0] sc_cnt_r, nc_r;
  logic [8:0] strength_r;
  logic [gbsd_pkg::LEVEL_W-1:0] level_r;
  logic [QW-1:0] head_r, tail_r, end_r;
  logic [AW-1:0] clr_r;
  logic [1:0] dir_r;
  logic [7:0] sig_r;
  logic out_v_r;
  logic tgt_ok_r;

  // memory ports
  logic g_we; logic [AW-1:0] g_wa, g_ra; logic [8:0] g_wd, g_rd;
  logic v_we; logic [AW-1:0] v_wa, v_ra; logic v_wd; logic [0:0] v_rd;
  logic q_we; logic [AW-1:0] q_wa, q_ra; logic [RW+CW-1:0] q_wd, q_rd;

  function automatic logic [AW-1:0] cidx(input logic [RW:0] r, input logic [CW:0] c);
    return AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  gbsd_ram #(.WIDTH(9),  .DEPTH(CELLS)) u_grid (.clk, .we(g_we), .waddr(g_wa),
    .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  gbsd_ram #(.WIDTH(1),  .DEPTH(CELLS)) u_vis (.clk, .we(v_we), .waddr(v_wa),
    .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  gbsd_ram #(.WIDTH(RW+CW), .DEPTH(CELLS)) u_que (.clk, .we(q_we), .waddr(q_wa),
    .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  // clamp configured extent
  assign m_w = (11'(rows_r) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_r);
  assign n_w = (11'(cols_r) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cols_r);

  assign busy      = (state_r != S_IDLE) || out_v_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_signal = sig_r;

  logic load_go;
  assign load_go = start && !busy && (in_kind == gbsd_pkg::KIND_LOAD) &&
                   (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);

  // neighbour candidate from current cell and direction
  logic nb_ok; logic [RW:0] nb_r; logic [CW:0] nb_c;
  always_comb begin
    nb_r = {1'b0, pr_r}; nb_c = {1'b0, pc_r}; nb_ok = 1'b0;
    unique case (dir_r)
      2'd0: begin nb_c = nb_c + 1'b1; nb_ok = 11'(nb_c) < n_w; end
      2'd1: begin nb_r = nb_r + 1'b1; nb_ok = 11'(nb_r) < m_w; end
      2'd2: begin nb_ok = pc_r != '0; nb_c = nb_c - 1'b1; end
      default: begin nb_ok = pr_r != '0; nb_r = nb_r - 1'b1; end
    endcase
  end

  // memory address and write control
  always_comb begin
    g_we = load_go;
    g_wa = cidx({1'b0, RW'(in_row)}, {1'b0, CW'(in_col)});
    g_wd = in_cell_value;
    g_ra = cidx(sr_cnt_r, sc_cnt_r);
    v_we = 1'b0; v_wa = clr_r; v_wd = 1'b0; v_ra = cidx(nr_r, nc_r);
    q_we = 1'b0; q_wa = tail_r[AW-1:0]; q_wd = {nr_r[RW-1:0], nc_r[CW-1:0]};
    q_ra = head_r[AW-1:0];
    unique case (state_r)
      S_CLR: v_we = 1'b1;
      S_NB_SEL, S_NB_WAIT, S_NB_CHK: g_ra = cidx(nr_r, nc_r);
      default: ;
    endcase
    if (state_r == S_DEQ_RD && head_r == '0 && tail_r == QW'(1) && level_r == '0) begin
      v_we = 1'b1; v_wa = cidx({1'b0, sr_r}, {1'b0, sc_r}); v_wd = 1'b1;
    end
    if (state_r == S_NB_CHK && g_rd == '0 && !v_rd[0] &&
        !(nr_r == {1'b0, trow_r} && nc_r == {1'b0, tcol_r})) begin
      v_we = 1'b1; v_wa = cidx(nr_r, nc_r); v_wd = 1'b1;
      q_we = 1'b1;
    end
  end

  logic [9:0] diff;
  assign diff = 10'(strength_r) - 10'(level_r > 13'd511 ? 13'd511 : level_r);

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rows_r <= 7'd64; cols_r <= 7'd64; out_v_r <= 1'b0;
      head_r <= '0; tail_r <= '0;
    end else begin
      out_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gbsd_pkg::REG_ROWS) rows_r <= cfg_data;
        if (cfg_index == gbsd_pkg::REG_COLS) cols_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: if (start && !busy && in_kind == gbsd_pkg::KIND_QUERY) begin
          trow_r <= RW'(in_row); tcol_r <= CW'(in_col);
          tgt_ok_r <= (11'(in_row) < m_w) && (11'(in_col) < n_w) &&
                      (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
          sr_cnt_r <= '0; sc_cnt_r <= '0;
          if (m_w == 0 || n_w == 0) begin
            sig_r <= '0; state_r <= S_DONE;
          end else state_r <= S_SCAN_RD;
        end
        S_SCAN_RD: state_r <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (!g_rd[8] && g_rd != '0) begin
            strength_r <= g_rd; sr_r <= sr_cnt_r[RW-1:0]; sc_r <= sc_cnt_r[CW-1:0];
            if (sr_cnt_r[RW-1:0] == trow_r && sc_cnt_r[CW-1:0] == tcol_r) begin
              sig_r <= g_rd[7:0]; state_r <= S_DONE;
            end else if (!tgt_ok_r) begin
              sig_r <= '0; state_r <= S_DONE;
            end else begin
              clr_r <= '0; state_r <= S_CLR;
            end
          end else if (11'(sc_cnt_r) + 1 < n_w) begin
            sc_cnt_r <= sc_cnt_r + 1'b1; state_r <= S_SCAN_RD;
          end else if (11'(sr_cnt_r) + 1 < m_w) begin
            sc_cnt_r <= '0; sr_cnt_r <= sr_cnt_r + 1'b1; state_r <= S_SCAN_RD;
          end else begin
            sig_r <= '0; state_r <= S_DONE;
          end
        end
        S_CLR: if (clr_r == AW'(CELLS - 1)) begin
          head_r <= '0; tail_r <= QW'(1); end_r <= '0; level_r <= '0;
          state_r <= S_DEQ_RD;
        end else clr_r <= clr_r + 1'b1;
        S_DEQ_RD: begin
          // first level: seed queue with source without memory read
          if (head_r == '0 && tail_r == QW'(1) && level_r == '0) begin
            pr_r <= sr_r; pc_r <= sc_r; head_r <= QW'(1); end_r <= QW'(1);
            level_r <= 13'd1; dir_r <= 2'd0; state_r <= S_NB_SEL;
          end else if (head_r == tail_r) begin
            sig_r <= '0; state_r <= S_DONE;
          end else begin
            if (head_r == end_r) begin
              end_r <= tail_r; level_r <= level_r + 1'b1;
            end
            state_r <= S_DEQ_WAIT;
          end
        end
        S_DEQ_WAIT: begin
          pr_r <= q_rd[RW+CW-1:CW]; pc_r <= q_rd[CW-1:0];
          head_r <= head_r + 1'b1; dir_r <= 2'd0; state_r <= S_NB_SEL;
        end
        S_NB_SEL: begin
          nr_r <= nb_r; nc_r <= nb_c;
          if (nb_ok) state_r <= S_NB_WAIT;
          else if (dir_r == 2'd3) state_r <= S_DEQ_RD;
          else dir_r <= dir_r + 1'b1;
        end
        S_NB_WAIT: state_r <= S_NB_CHK;
        S_NB_CHK: begin
          if (g_rd == '0 && !v_rd[0] &&
              nr_r == {1'b0, trow_r} && nc_r == {1'b0, tcol_r}) begin
            sig_r <= diff[9] || diff == '0 ? 8'd0 : diff[7:0];
            state_r <= S_DONE;
          end else begin
            if (g_rd == '0 && !v_rd[0]) tail_r <= tail_r + 1'b1;
            if (dir_r == 2'd3) state_r <= S_DEQ_RD;
            else begin dir_r <= dir_r + 1'b1; state_r <= S_NB_SEL; end
          end
        end
        S_DONE: begin out_v_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result not issued");
  assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue underrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("idle while issuing");
endmodule
`default_nettype wire

// File: verif/grid_bfs_signal_decay_tb.sv
`timescale 1ns / 1ps
module grid_bfs_signal_decay_tb;

  localparam int GRID_DIM = 64;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
  localparam int START_DIM = 4;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {STEP_LOAD, STEP_QUERY, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t                     op;
    logic [5:0]                     row;
    logic [5:0]                     col;
    logic signed [8:0]              value;
    logic [gbsd_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [6:0]                     reg_data;
    bit                             typed;
    logic [7:0]                     typed_signal;
  } plan_step_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_kind;
  logic [5:0] in_row;
  logic [5:0] in_col;
  logic signed [8:0] in_cell_value;
  logic out_valid;
  logic [7:0] out_signal;
  logic cfg_valid;
  logic cfg_ready;
  logic [gbsd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [6:0] cfg_data;

  // Shadow copy of the grid and the size registers
  logic signed [8:0] grid_shadow [GRID_CELLS];
  logic [6:0] rows_shadow;
  logic [6:0] cols_shadow;

  logic [7:0] signal_q [$];
  plan_step_t directed_plan [$];
  int errors;
  int idle_pct;
  int cycle_count;
  logic [7:0] want_signal;

  grid_bfs_signal_decay DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_row(in_row), .in_col(in_col),
    .in_cell_value(in_cell_value), .out_valid(out_valid), .out_signal(out_signal),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Decayed signal from the first source over a four-neighbour search
  function automatic logic [7:0] decayed_signal(int trow, int tcol);
    int m, n, sr, sc, strength, head, tail, level, stop, idx, pr, pc, nr, nc, ni, d, v;
    bit found;
    bit seen [GRID_CELLS];
    int frontier [GRID_CELLS];
    m = (rows_shadow > GRID_DIM) ? GRID_DIM : rows_shadow;
    n = (cols_shadow > GRID_DIM) ? GRID_DIM : cols_shadow;
    found = 0;
    sr = 0;
    sc = 0;
    strength = 0;
    for (int r = 0; r < m && !found; r++)
      for (int c = 0; c < n && !found; c++)
        if (grid_shadow[r*GRID_DIM+c] > 0) begin
          found = 1;
          sr = r;
          sc = c;
          strength = grid_shadow[r*GRID_DIM+c];
        end
    if (!found) return 8'd0;
    if (sr == trow && sc == tcol) return strength[7:0];
    if (trow >= m || tcol >= n) return 8'd0;
    head = 0;
    tail = 0;
    frontier[tail++] = sr*GRID_DIM + sc;
    seen[sr*GRID_DIM+sc] = 1;
    level = 0;
    while (head < tail) begin
      stop = tail;
      level++;
      while (head < stop) begin
        idx = frontier[head++];
        pr = idx / GRID_DIM;
        pc = idx % GRID_DIM;
        for (d = 0; d < 4; d++) begin
          nr = pr;
          nc = pc;
          if (d == 0) begin
            if (pc + 1 >= n) continue;
            nc = pc + 1;
          end else if (d == 1) begin
            if (pr + 1 >= m) continue;
            nr = pr + 1;
          end else if (d == 2) begin
            if (pc == 0) continue;
            nc = pc - 1;
          end else begin
            if (pr == 0) continue;
            nr = pr - 1;
          end
          ni = nr*GRID_DIM + nc;
          if (grid_shadow[ni] != 0 || seen[ni]) continue;
          if (nr == trow && nc == tcol) begin
            v = strength - level;
            return (v > 0) ? v[7:0] : 8'd0;
          end
          seen[ni] = 1;
          frontier[tail++] = ni;
        end
      end
    end
    return 8'd0;
  endfunction

  // Issue one request and book its expectation on acceptance; start stays high
  task automatic send_request(logic kind, logic [5:0] row, logic [5:0] col,
                              logic signed [8:0] value, bit typed, logic [7:0] typed_signal);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_row <= row;
    in_col <= col;
    in_cell_value <= value;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (kind == gbsd_pkg::KIND_LOAD)
      grid_shadow[row*GRID_DIM+col] = value;
    else
      signal_q.insert(signal_q.size(), typed ? typed_signal : decayed_signal(row, col));
  endtask

  // Drop start and hold off until every result is back
  task automatic drain();
    start <= 1'b0;
    wait (signal_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drain, settle, then write one size register
  task automatic write_reg(logic [gbsd_pkg::CFG_IDX_W-1:0] idx, logic [6:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gbsd_pkg::REG_ROWS) rows_shadow = data;
    else cols_shadow = data;
  endtask

  function automatic void plan(step_kind_t op, int row, int col, int value,
                               bit typed = 0, int typed_signal = 0,
                               logic [gbsd_pkg::CFG_IDX_W-1:0] idx = gbsd_pkg::REG_ROWS,
                               int data = 0);
    plan_step_t s;
    s.op = op;
    s.row = 6'(row);
    s.col = 6'(col);
    s.value = 9'(value);
    s.reg_idx = idx;
    s.reg_data = 7'(data);
    s.typed = typed;
    s.typed_signal = 8'(typed_signal);
    directed_plan.insert(directed_plan.size(), s);
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (signal_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual signal=%0d",
                 $time, out_signal);
        errors++;
      end else begin
        want_signal = signal_q[0];
        signal_q.delete(0);
        if (out_signal !== want_signal) begin
          $display("%0t: signal mismatch, expected %0d, actual %0d",
                   $time, want_signal, out_signal);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int m, n;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = gbsd_pkg::KIND_LOAD;
    in_row = '0;
    in_col = '0;
    in_cell_value = '0;
    cfg_valid = 1'b0;
    cfg_index = gbsd_pkg::REG_ROWS;
    cfg_data = '0;
    errors = 0;
    idle_pct = 0;
    cycle_count = 0;
    rows_shadow = 7'd64;
    cols_shadow = 7'd64;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Shrink the grid and write every cell in use before any query
    write_reg(gbsd_pkg::REG_ROWS, 7'(START_DIM));
    write_reg(gbsd_pkg::REG_COLS, 7'(START_DIM));
    for (int i = 0; i < START_DIM*START_DIM; i++)
      send_request(gbsd_pkg::KIND_LOAD, 6'(i / START_DIM), 6'(i % START_DIM), 9'sd0, 0, 0);

    // Directed checks: no source, walls, decay and size extremes
    plan(STEP_QUERY, 0, 0, 0, 1, 0);
    plan(STEP_LOAD, 0, 0, 255);
    plan(STEP_QUERY, 0, 0, 0, 1, 255);
    plan(STEP_QUERY, 3, 3, 0);
    plan(STEP_LOAD, 0, 1, -1);
    plan(STEP_LOAD, 1, 0, -1);
    plan(STEP_QUERY, 2, 2, 0, 1, 0);
    plan(STEP_QUERY, 0, 1, 0, 1, 0);
    plan(STEP_LOAD, 0, 1, 0);
    plan(STEP_LOAD, 1, 0, -256);
    plan(STEP_QUERY, 1, 1, 0);
    plan(STEP_LOAD, 1, 0, 0);
    plan(STEP_LOAD, 3, 3, 7);
    plan(STEP_QUERY, 3, 3, 0, 1, 0);
    plan(STEP_LOAD, 0, 0, 1);
    plan(STEP_QUERY, 0, 3, 0, 1, 0);
    plan(STEP_QUERY, 0, 1, 0, 1, 0);
    plan(STEP_CFG, 0, 0, 0, 0, 0, gbsd_pkg::REG_ROWS, 1);
    plan(STEP_CFG, 0, 0, 0, 0, 0, gbsd_pkg::REG_COLS, 1);
    plan(STEP_QUERY, 0, 0, 0, 1, 1);
    plan(STEP_QUERY, 0, 1, 0, 1, 0);
    plan(STEP_CFG, 0, 0, 0, 0, 0, gbsd_pkg::REG_ROWS, 0);
    plan(STEP_QUERY, 0, 0, 0, 1, 0);
    // Wall in the source so a full-size query only touches written cells
    plan(STEP_LOAD, 0, 0, 200);
    plan(STEP_LOAD, 0, 1, -1);
    plan(STEP_LOAD, 1, 0, -1);
    plan(STEP_CFG, 0, 0, 0, 0, 0, gbsd_pkg::REG_ROWS, 127);
    plan(STEP_CFG, 0, 0, 0, 0, 0, gbsd_pkg::REG_COLS, 127);
    plan(STEP_QUERY, 0, 0, 0, 1, 200);
    plan(STEP_QUERY, 63, 63, 0, 1, 0);
    foreach (directed_plan[i]) begin
      case (directed_plan[i].op)
        STEP_LOAD: send_request(gbsd_pkg::KIND_LOAD, directed_plan[i].row,
                                directed_plan[i].col, directed_plan[i].value, 0, 0);
        STEP_QUERY: send_request(gbsd_pkg::KIND_QUERY, directed_plan[i].row,
                                 directed_plan[i].col, 9'($urandom()),
                                 directed_plan[i].typed, directed_plan[i].typed_signal);
        default: write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
      endcase
    end

    // Random phases: small grids with one or two sources, walls and noise
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 87;
        default: idle_pct = 32;
      endcase
      m = $urandom_range(START_DIM, 1);
      n = $urandom_range(START_DIM, 1);
      write_reg(gbsd_pkg::REG_ROWS, 7'(m));
      write_reg(gbsd_pkg::REG_COLS, 7'(n));
      for (int i = 0; i < m*n; i++)
        send_request(gbsd_pkg::KIND_LOAD, 6'(i / n), 6'(i % n), 9'sd0, 0, 0);
      for (int i = 0; i < m*n/4; i++)
        send_request(gbsd_pkg::KIND_LOAD, 6'($urandom_range(m-1)), 6'($urandom_range(n-1)),
                     9'(($urandom_range(3) == 0) ? -int'($urandom_range(256, 2)) : -1),
                     0, 0);
      send_request(gbsd_pkg::KIND_LOAD, 6'($urandom_range(m-1)), 6'($urandom_range(n-1)),
                   9'(($urandom_range(1)) ? $urandom_range(12, 1) : $urandom_range(255, 1)),
                   0, 0);
      if ($urandom_range(3) == 0)
        send_request(gbsd_pkg::KIND_LOAD, 6'($urandom_range(m-1)), 6'($urandom_range(n-1)),
                     9'($urandom_range(255, 1)), 0, 0);
      for (int q = 0; q < 8; q++) begin
        if ($urandom_range(9) == 0)
          send_request(gbsd_pkg::KIND_QUERY, 6'($urandom_range(63)), 6'($urandom_range(63)),
                       9'($urandom()), 0, 0);
        else
          send_request(gbsd_pkg::KIND_QUERY, 6'($urandom_range(m-1)),
                       6'($urandom_range(n-1)), 9'($urandom()), 0, 0);
        // Hold off until every result is back
        if (q == 3) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
